// ----- rtl/wst_pkg.sv -----
`default_nettype none

package wst_pkg;

	// request codes
	localparam logic [1:0] FUNC_SET    = 2'd0;
	localparam logic [1:0] FUNC_LOOKUP = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;

	// unsigned q8.24 constants
	localparam logic [31:0] ONE_Q824 = 32'h0100_0000;
	localparam logic [31:0] MAX_Q824 = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} wst_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic issue;
		logic finish;
	} wst_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_func;
		logic empty;
		logic last;
		logic out_hold;
	} wst_sts_t;

endpackage

`default_nettype wire

// ----- rtl/wst_ctrl.sv -----
`default_nettype none

module wst_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire wst_pkg::wst_sts_t sts,
	output wst_pkg::wst_cmd_t      cmd
);
	import wst_pkg::*;

	wst_state_t state_q;
	wst_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_START;
			end
			ST_START: begin
				if (sts.scan_func && !sts.empty) state_d = ST_SCAN;
				else state_d = ST_FINISH;
			end
			ST_SCAN: begin
				if (sts.last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!sts.out_hold) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall   = (state_q != ST_IDLE);
		cmd.load   = (state_q == ST_IDLE) && in_valid;
		cmd.issue  = (state_q == ST_SCAN);
		cmd.finish = (state_q == ST_FINISH) && !sts.out_hold;
	end

endmodule

`default_nettype wire

// ----- rtl/wst_datapath.sv -----
`default_nettype none

module wst_datapath #(
	parameter int TABLE_DEPTH = 16,
	parameter int KEY_WIDTH   = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire wst_pkg::wst_cmd_t cmd,
	output wst_pkg::wst_sts_t      sts,
	input  wire logic [1:0]        func,
	input  wire logic [7:0]        col_type,
	input  wire logic [7:0]        tag,
	input  wire logic [31:0]       scale,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [31:0]            product,
	output logic                   status
);
	import wst_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	typedef struct packed {
		logic [KEY_WIDTH-1:0] col;
		logic [KEY_WIDTH-1:0] tag;
		logic [31:0]          factor;
	} entry_t;

	entry_t mem [TABLE_DEPTH];

	// request
	logic [1:0]           func_q;
	logic [KEY_WIDTH-1:0] col_q;
	logic [KEY_WIDTH-1:0] tag_q;
	logic [31:0]          scale_q;

	// scan
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] idx_s1;
	logic             rd_vld_s1;
	entry_t           rd_s1;
	logic [31:0]      acc_q;
	logic             found_q;
	logic [IDX_W-1:0] found_idx_q;
	logic [CNT_W-1:0] count_q;

	// output register
	logic        out_valid_q;
	logic [31:0] product_q;
	logic        status_q;

	logic        is_set;
	logic        is_lookup;
	logic        full;
	logic        wild_hit;
	logic        exact_hit;
	logic [63:0] mul_full;
	logic [39:0] mul_shr;
	logic [31:0] mul_sat;

	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;

	assign is_set    = (func_q == FUNC_SET);
	assign is_lookup = (func_q == FUNC_LOOKUP);
	assign full      = (count_q == CNT_W'(TABLE_DEPTH));

	assign wild_hit  = ((rd_s1.col == '0) || (rd_s1.col == col_q)) &&
	                   ((rd_s1.tag == '0) || (rd_s1.tag == tag_q));
	assign exact_hit = (rd_s1.col == col_q) && (rd_s1.tag == tag_q);

	// truncate the q8.24 product, then saturate
	assign mul_full = 64'(acc_q) * 64'(rd_s1.factor);
	assign mul_shr  = mul_full[63:24];
	assign mul_sat  = (mul_shr[39:32] != '0) ? MAX_Q824 : mul_shr[31:0];

	assign sts.scan_func = is_set || is_lookup;
	assign sts.empty     = (count_q == '0);
	assign sts.last      = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign sts.out_hold  = out_valid_q && out_stall;

	// a replace rewrites the same keys, so one write port serves both cases
	always_comb begin
		wr_en   = cmd.finish && is_set && (found_q || !full);
		wr_addr = found_q ? found_idx_q : count_q[IDX_W-1:0];
		wr_data = '{col: col_q, tag: tag_q, factor: scale_q};
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_s1 <= mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			col_q   <= KEY_WIDTH'(col_type);
			tag_q   <= KEY_WIDTH'(tag);
			scale_q <= scale;
			idx_q   <= '0;
			acc_q   <= ONE_Q824;
			found_q <= 1'b0;
		end else begin
			if (cmd.issue) begin
				idx_q  <= idx_q + IDX_W'(1);
				idx_s1 <= idx_q;
			end
			if (rd_vld_s1) begin
				if (is_lookup && wild_hit) acc_q <= mul_sat;
				if (is_set && exact_hit && !found_q) begin
					found_q     <= 1'b1;
					found_idx_q <= idx_s1;
				end
			end
		end
		if (cmd.finish) begin
			product_q <= is_lookup ? acc_q : '0;
			status_q  <= is_set && !found_q && full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.issue;
			if (cmd.finish) begin
				if (func_q == FUNC_CLEAR) count_q <= '0;
				else if (is_set && !found_q && !full) count_q <= count_q + CNT_W'(1);
			end
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign product   = product_q;
	assign status    = status_q;

endmodule

`default_nettype wire

// ----- rtl/wildcard_scale_table_top.sv -----
// lookup and set walk the used slots (at most TABLE_DEPTH) one slot per cycle through the
//   table memory and its single q8.24 multiplier; clear, unused codes and an empty table
//   skip the walk; one request is in flight at a time, so a new request is taken only
//   once the result of the last one has been posted to the output register
// reset: arst_n empties the table at once (used count to zero); the memory is not cleared
`default_nettype none

module wildcard_scale_table_top #(
	parameter int TABLE_DEPTH = 16,
	parameter int KEY_WIDTH   = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  func,
	input  wire logic [7:0]  col_type,
	input  wire logic [7:0]  tag,
	input  wire logic [31:0] scale,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      product,
	output logic             status
);
	import wst_pkg::*;

	// command and status between sequencer and table datapath
	wst_cmd_t cmd;
	wst_sts_t sts;

	// sequencer: takes a request, walks the used slots for a set or lookup, then posts the
	// result once the output register is free
	wst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: slot memory with registered read, key compare, truncating
	// saturating multiply-accumulate, used count and the output register
	wst_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_WIDTH   (KEY_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.func      (func),
		.col_type  (col_type),
		.tag       (tag),
		.scale     (scale),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.product   (product),
		.status    (status)
	);

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import wst_pkg::*;

	localparam int TABLE_DEPTH = 16;
	localparam int KEY_WIDTH   = 8;
	// the one func code the block ignores
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	// cycles with no transfer on either side before the run is given up
	localparam int STALL_LIMIT = 5000;
	// cycles allowed after the last result for anything stray to show up
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_ITEMS = 1820;

	// idling phases: receiver-heavy, sender-heavy, no idling
	localparam logic [1:0] PH_SEND_IDLE = 2'd0;
	localparam logic [1:0] PH_RECV_IDLE = 2'd1;
	localparam logic [1:0] PH_NO_IDLE   = 2'd2;

	typedef struct packed {
		logic [1:0]  code;
		logic [7:0]  column;
		logic [7:0]  tag_key;
		logic [31:0] factor;
		logic [1:0]  phase;
	} request_t;

	typedef struct packed {
		logic [31:0] product;
		logic        status;
	} scale_result_t;

	// clock, reset and block inputs, all known from time zero
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [1:0]  func      = FUNC_SET;
	logic [7:0]  col_type  = 8'd0;
	logic [7:0]  tag       = 8'd0;
	logic [31:0] scale     = 32'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] product;
	logic        status;

	// requests still to be sent, head is the one on the bus
	request_t      pending_reqs[$];
	// predicted results, oldest first
	scale_result_t expected_results[$];
	// idling phase of the most recent request transfer, steers the receiver
	logic [1:0]    rx_phase = PH_SEND_IDLE;
	int            mismatches = 0;
	int            quiet_cycles = 0;

	// shadow copy of the rule table; slots 0 to rule_count-1 are live, in insertion order
	logic [7:0]  rule_col[TABLE_DEPTH];
	logic [7:0]  rule_tag[TABLE_DEPTH];
	logic [31:0] rule_factor[TABLE_DEPTH];
	int          rule_count = 0;

	wildcard_scale_table_top #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.KEY_WIDTH  (KEY_WIDTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.col_type (col_type),
		.tag      (tag),
		.scale    (scale),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.product  (product),
		.status   (status)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// q8.24 multiply: truncate the 64-bit product, saturate at the top
	function automatic logic [31:0] q824_mul(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = ({32'd0, a} * {32'd0, b}) >> 24;
		return (|p[63:32]) ? MAX_Q824 : p[31:0];
	endfunction

	// applies one request to the shadow table and returns what the block should answer
	function automatic scale_result_t apply_request(input request_t rq);
		scale_result_t res;
		bit            hit;
		int            i;
		res.product = 32'd0;
		res.status  = 1'b0;
		hit         = 1'b0;
		case (rq.code)
			FUNC_SET: begin
				// exact key match replaces the factor of the first such rule
				for (i = 0; i < rule_count; i++) begin
					if (!hit && rule_col[i] == rq.column && rule_tag[i] == rq.tag_key) begin
						rule_factor[i] = rq.factor;
						hit = 1'b1;
					end
				end
				if (!hit) begin
					if (rule_count < TABLE_DEPTH) begin
						rule_col[rule_count]    = rq.column;
						rule_tag[rule_count]    = rq.tag_key;
						rule_factor[rule_count] = rq.factor;
						rule_count++;
					end else begin
						// table full, rule dropped
						res.status = 1'b1;
					end
				end
			end
			FUNC_LOOKUP: begin
				// stored key of zero is a wildcard
				res.product = ONE_Q824;
				for (i = 0; i < rule_count; i++) begin
					if ((rule_tag[i] == 8'd0 || rule_tag[i] == rq.tag_key) &&
					    (rule_col[i] == 8'd0 || rule_col[i] == rq.column))
						res.product = q824_mul(res.product, rule_factor[i]);
				end
			end
			FUNC_CLEAR: begin
				rule_count = 0;
			end
			default: begin
				// unused code leaves the table alone
			end
		endcase
		return res;
	endfunction

	function automatic int send_idle_pct(input logic [1:0] ph);
		return (ph == PH_SEND_IDLE) ? 34 : (ph == PH_RECV_IDLE) ? 46 : 0;
	endfunction

	function automatic int recv_idle_pct(input logic [1:0] ph);
		return (ph == PH_SEND_IDLE) ? 46 : (ph == PH_RECV_IDLE) ? 34 : 0;
	endfunction

	task automatic queue_request(input logic [1:0] code, input logic [7:0] column,
			input logic [7:0] tag_key, input logic [31:0] factor, input logic [1:0] phase);
		request_t rq;
		rq.code    = code;
		rq.column  = column;
		rq.tag_key = tag_key;
		rq.factor  = factor;
		rq.phase   = phase;
		pending_reqs.push_back(rq);
	endtask

	// keys mostly from a small pool so rules collide, match and wildcard each other
	function automatic logic [7:0] pick_key();
		return ($urandom_range(9) < 7) ? 8'($urandom_range(4)) : 8'($urandom_range(255));
	endfunction

	// factors mostly near 1.0 so long products stay interesting
	function automatic logic [31:0] pick_factor();
		case ($urandom_range(7))
			0: return 32'd0;
			1: return MAX_Q824;
			2: return $urandom;
			3: return ONE_Q824;
			default: return $urandom_range(32'h0140_0000, 32'h00C0_0000);
		endcase
	endfunction

	// request driver: one transfer per accepted cycle, random gaps per phase
	always @(posedge clk) begin : request_driver
		bit fire;
		if (arst_n) begin
			fire = in_valid && !in_stall;
			if (fire) begin
				// accepted transfer: predict its result and retire it
				rx_phase <= pending_reqs[0].phase;
				expected_results.push_back(apply_request(pending_reqs.pop_front()));
			end
			// a stalled payload holds; otherwise offer the next request or idle
			if (!in_valid || fire) begin
				if (pending_reqs.size() > 0 &&
				    $urandom_range(99) >= send_idle_pct(pending_reqs[0].phase)) begin
					in_valid <= 1'b1;
					func     <= pending_reqs[0].code;
					col_type <= pending_reqs[0].column;
					tag      <= pending_reqs[0].tag_key;
					scale    <= pending_reqs[0].factor;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: compare each result transfer with the oldest prediction
	always @(posedge clk) begin : result_monitor
		scale_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result with nothing expected: product %h status %0d",
						product, status);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (product !== want.product) begin
						$error("product: expected %h, actual %h", want.product, product);
						mismatches++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						mismatches++;
					end
				end
			end
			// receiver backpressure follows the phase of the latest request
			out_stall <= ($urandom_range(99) < recv_idle_pct(rx_phase));
		end
	end

	// watchdog: give up when neither channel moves for too long
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("** wildcard_scale_table_top: FAILED **");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		int       n;
		int       r;
		int       i;
		logic [1:0] ph;

		// directed: empty table, wildcard rule, saturation, replace, unused code
		queue_request(FUNC_CLEAR, 8'd0, 8'd0, 32'd0, PH_SEND_IDLE);
		queue_request(FUNC_LOOKUP, 8'd0, 8'd0, 32'd0, PH_SEND_IDLE);
		queue_request(FUNC_SET, 8'd0, 8'd0, MAX_Q824, PH_SEND_IDLE);
		queue_request(FUNC_SET, 8'hFF, 8'hFF, 32'h0200_0000, PH_SEND_IDLE);
		queue_request(FUNC_LOOKUP, 8'hFF, 8'hFF, 32'hFFFF_FFFF, PH_SEND_IDLE);
		queue_request(FUNC_SET, 8'hFF, 8'hFF, 32'd0, PH_SEND_IDLE);
		queue_request(FUNC_LOOKUP, 8'hFF, 8'hFF, 32'd0, PH_SEND_IDLE);
		queue_request(FUNC_LOOKUP, 8'd1, 8'd1, 32'd0, PH_SEND_IDLE);
		queue_request(FUNC_UNUSED, 8'hA5, 8'h5A, 32'hDEAD_BEEF, PH_SEND_IDLE);
		// column-only rule, tag wildcard, factor below 1.0 scales a saturated value
		queue_request(FUNC_SET, 8'd5, 8'd0, 32'h0080_0000, PH_SEND_IDLE);
		queue_request(FUNC_LOOKUP, 8'd5, 8'd9, 32'd0, PH_SEND_IDLE);
		// fill the remaining slots
		for (i = 0; i < TABLE_DEPTH - 3; i++)
			queue_request(FUNC_SET, 8'(10 + i), 8'(20 + i), ONE_Q824 + 32'(i), PH_SEND_IDLE);
		// new rule on a full table is dropped, a replace still works
		queue_request(FUNC_SET, 8'd77, 8'd77, ONE_Q824, PH_SEND_IDLE);
		queue_request(FUNC_SET, 8'd5, 8'd0, 32'h0040_0000, PH_SEND_IDLE);
		queue_request(FUNC_LOOKUP, 8'd5, 8'd9, 32'd0, PH_SEND_IDLE);
		queue_request(FUNC_CLEAR, 8'hFF, 8'hFF, MAX_Q824, PH_SEND_IDLE);
		queue_request(FUNC_LOOKUP, 8'd5, 8'd9, 32'd0, PH_SEND_IDLE);

		// random: runs of sets and lookups between occasional clears
		n = 0;
		while (n < RANDOM_ITEMS) begin
			ph = (n < RANDOM_ITEMS / 3) ? PH_SEND_IDLE :
			     (n < 2 * RANDOM_ITEMS / 3) ? PH_RECV_IDLE : PH_NO_IDLE;
			r = $urandom_range(99);
			if (r < 42) begin
				queue_request(FUNC_SET, pick_key(), pick_key(), pick_factor(), ph);
				n++;
			end else if (r < 95) begin
				queue_request(FUNC_LOOKUP, pick_key(), pick_key(), $urandom, ph);
				n++;
			end else if (r < 97) begin
				queue_request(FUNC_CLEAR, 8'($urandom), 8'($urandom), $urandom, ph);
				n++;
			end else begin
				// ignored by the block, not counted
				queue_request(FUNC_UNUSED, 8'($urandom), 8'($urandom), $urandom, ph);
			end
		end

		// single reset at the start
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// all requests sent, all results back, then a short quiet window
		while (pending_reqs.size() != 0) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("** wildcard_scale_table_top: PASSED **");
		else
			$display("** wildcard_scale_table_top: FAILED **");
		$finish;
	end

endmodule
